@@ rtl/core/dwma_pkg.sv @@
// ----------------------------------------------------------------------------
// dwma_pkg
// shared constants, types and the decimal text helper of the dual window
// moving average
// ----------------------------------------------------------------------------
package dwma_pkg;

    localparam int SAMPLE_W         = 8;
    localparam int AVG_W            = 8;
    localparam int CHAR_W           = 6;
    localparam int SUM_W            = 10;

    localparam int SHORT_WINDOW_DEF = 8;
    localparam int LONG_WINDOW_DEF  = 50;

    // floor(x / 3) == (x * 683) >> 11 for every x up to 765
    localparam logic [SUM_W-1:0] DIV3_MUL   = 10'd683;
    localparam int               DIV3_SHIFT = 11;

    localparam logic [CHAR_W-1:0] ASCII_SPACE = 6'd32;
    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;

    typedef struct packed {
        logic [CHAR_W-1:0] c0;
        logic [CHAR_W-1:0] c1;
        logic [CHAR_W-1:0] c2;
    } t_text;

    // left-justified decimal of 0..255, space padded
    // hundreds via *41>>12, tens via *205>>11
    function automatic t_text to_text(input logic [AVG_W-1:0] v);
        logic [14:0] ph;
        logic [1:0]  h;
        logic [6:0]  rem;
        logic [14:0] pt;
        logic [3:0]  t;
        logic [3:0]  u;
        t_text       txt;
        ph  = 15'(v) * 15'd41;
        h   = ph[13:12];
        rem = 7'(v - 8'(h) * 8'd100);
        pt  = 15'(rem) * 15'd205;
        t   = pt[14:11];
        u   = 4'(rem - 7'(t) * 7'd10);
        if (v >= 8'd100) begin
            txt.c0 = ASCII_ZERO + 6'(h);
            txt.c1 = ASCII_ZERO + 6'(t);
            txt.c2 = ASCII_ZERO + 6'(u);
        end else if (v >= 8'd10) begin
            txt.c0 = ASCII_ZERO + 6'(t);
            txt.c1 = ASCII_ZERO + 6'(u);
            txt.c2 = ASCII_SPACE;
        end else begin
            txt.c0 = ASCII_ZERO + 6'(u);
            txt.c1 = ASCII_SPACE;
            txt.c2 = ASCII_SPACE;
        end
        return txt;
    endfunction

endpackage

@@ rtl/core/dwma_if.sv @@
// ----------------------------------------------------------------------------
// dwma_if
// valid/ready channels of the dual window moving average
// ----------------------------------------------------------------------------
interface dwma_in_if;
    logic                           valid;
    logic                           ready;
    logic [dwma_pkg::SAMPLE_W-1:0]  sample_a;
    logic [dwma_pkg::SAMPLE_W-1:0]  sample_b;
    logic [dwma_pkg::SAMPLE_W-1:0]  sample_c;

    modport source (output valid, sample_a, sample_b, sample_c, input ready);
    modport sink   (input valid, sample_a, sample_b, sample_c, output ready);
endinterface

interface dwma_out_if;
    logic                         valid;
    logic                         ready;
    logic [dwma_pkg::AVG_W-1:0]   short_average;
    logic [dwma_pkg::AVG_W-1:0]   long_average;
    logic [dwma_pkg::CHAR_W-1:0]  short_char0;
    logic [dwma_pkg::CHAR_W-1:0]  short_char1;
    logic [dwma_pkg::CHAR_W-1:0]  short_char2;
    logic [dwma_pkg::CHAR_W-1:0]  long_char0;
    logic [dwma_pkg::CHAR_W-1:0]  long_char1;
    logic [dwma_pkg::CHAR_W-1:0]  long_char2;

    modport source (output valid, short_average, long_average, short_char0, short_char1,
                    short_char2, long_char0, long_char1, long_char2, input ready);
    modport sink   (input valid, short_average, long_average, short_char0, short_char1,
                    short_char2, long_char0, long_char1, long_char2, output ready);
endinterface

@@ rtl/core/dwma_ring.sv @@
// ----------------------------------------------------------------------------
// dwma_ring
// ring buffer with running sum and constant-divisor mean
// ----------------------------------------------------------------------------
module dwma_ring #(
    parameter int DEPTH = dwma_pkg::SHORT_WINDOW_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_adv,
    input  logic                       i_push,
    input  logic [dwma_pkg::AVG_W-1:0] i_value,
    output logic [dwma_pkg::AVG_W-1:0] o_avg
);

    localparam int SLOT_W = $clog2(DEPTH);
    localparam int TOT_W  = $clog2(DEPTH * 255 + 1);
    localparam int DIV_K  = TOT_W + $clog2(DEPTH);
    localparam int M_W    = TOT_W + 2;
    localparam int PROD_W = TOT_W + M_W;
    localparam longint DIV_M = ((longint'(1) << DIV_K) + longint'(DEPTH) - 1)
                               / longint'(DEPTH);
    localparam logic [M_W-1:0]    MUL_C = M_W'(DIV_M);
    localparam logic [SLOT_W-1:0] LAST  = SLOT_W'(DEPTH - 1);

    logic [dwma_pkg::AVG_W-1:0] r_mem [DEPTH];
    logic [dwma_pkg::AVG_W-1:0] r_rd;
    logic [SLOT_W-1:0]          r_slot;
    logic [SLOT_W-1:0]          n_slot;
    logic                       r_full;
    logic [TOT_W-1:0]           r_total;
    logic [TOT_W-1:0]           n_total;
    logic [dwma_pkg::AVG_W-1:0] old_val;
    logic                       wrap;
    logic [PROD_W-1:0]          prod;
    logic [dwma_pkg::AVG_W-1:0] r_avg;

    assign wrap    = (r_slot == LAST);
    assign n_slot  = wrap ? '0 : r_slot + SLOT_W'(1);
    // entry read ahead is only meaningful once the ring has wrapped
    assign old_val = r_full ? r_rd : '0;
    assign n_total = r_total - TOT_W'(old_val) + TOT_W'(i_value);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= '0;
            r_full  <= 1'b0;
            r_total <= '0;
        end else if (i_push) begin
            r_slot  <= n_slot;
            r_full  <= r_full | wrap;
            r_total <= n_total;
        end
    end

    // write current slot, read ahead the slot replaced by the next push
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_slot] <= i_value;
            r_rd          <= r_mem[n_slot];
        end
    end

    assign prod = PROD_W'(r_total) * PROD_W'(MUL_C);

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_avg <= prod[DIV_K +: dwma_pkg::AVG_W];
        end
    end

    assign o_avg = r_avg;

endmodule

@@ rtl/core/dual_window_moving_average_top.sv @@
// ----------------------------------------------------------------------------
// dual_window_moving_average_top
// boxcar moving average over a short and a long window, with decimal text
// ----------------------------------------------------------------------------
// Each input transfer carries three 8-bit samples; their sum is divided by
// three and the result enters two ring buffers (SHORT_WINDOW and LONG_WINDOW
// deep) that keep running sums. Every input transfer yields exactly one output
// transfer with both truncated means and their left-justified, space padded
// ASCII text. The block takes one transfer per clock unless the output stalls.
// An item passes five registers: sample sum register, divide-by-three
// register, running sum register, mean register, text register; output valid
// is registered together with the text. The whole pipeline advances whenever
// the output register is empty or being taken, so a full output with ready
// low stalls the input. The ring memories read the slot to be replaced one
// push ahead, so a sum update per cycle needs one write and one registered
// read per ring. After reset the rings count as zero without any clearing
// pass; the means ramp up from zero.
// ----------------------------------------------------------------------------
module dual_window_moving_average_top #(
    parameter int SHORT_WINDOW = dwma_pkg::SHORT_WINDOW_DEF,
    parameter int LONG_WINDOW  = dwma_pkg::LONG_WINDOW_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dwma_in_if.sink       i_in,
    dwma_out_if.source    o_out
);

    // valid bits of the five stages
    logic [4:0]                      r_vld;
    logic                            adv;

    logic [dwma_pkg::SUM_W-1:0]      r_sum;
    logic [dwma_pkg::AVG_W-1:0]      r_comb;
    logic [2*dwma_pkg::SUM_W-1:0]    comb_prod;

    logic [dwma_pkg::AVG_W-1:0]      short_avg;
    logic [dwma_pkg::AVG_W-1:0]      long_avg;
    logic [dwma_pkg::AVG_W-1:0]      r_short_avg;
    logic [dwma_pkg::AVG_W-1:0]      r_long_avg;
    dwma_pkg::t_text                 r_short_txt;
    dwma_pkg::t_text                 r_long_txt;

    // pipeline moves when the output register is free or being taken
    assign adv        = !r_vld[4] || o_out.ready;
    assign i_in.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[3:0], i_in.valid};
        end
    end

    // stage 1: sum of the three samples
    // stage 2: divide by three through a reciprocal multiply
    assign comb_prod = (2*dwma_pkg::SUM_W)'(r_sum) * (2*dwma_pkg::SUM_W)'(dwma_pkg::DIV3_MUL);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sum  <= dwma_pkg::SUM_W'(i_in.sample_a) + dwma_pkg::SUM_W'(i_in.sample_b)
                      + dwma_pkg::SUM_W'(i_in.sample_c);
            r_comb <= comb_prod[dwma_pkg::DIV3_SHIFT +: dwma_pkg::AVG_W];
        end
    end

    // stages 3 and 4: running sums and means, state changes only on real items
    dwma_ring #(
        .DEPTH   (SHORT_WINDOW)
    ) u_short_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_push  (adv && r_vld[1]),
        .i_value (r_comb),
        .o_avg   (short_avg)
    );

    dwma_ring #(
        .DEPTH   (LONG_WINDOW)
    ) u_long_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_push  (adv && r_vld[1]),
        .i_value (r_comb),
        .o_avg   (long_avg)
    );

    // stage 5: decimal text, output register
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_short_avg <= short_avg;
            r_long_avg  <= long_avg;
            r_short_txt <= dwma_pkg::to_text(short_avg);
            r_long_txt  <= dwma_pkg::to_text(long_avg);
        end
    end

    assign o_out.valid         = r_vld[4];
    assign o_out.short_average = r_short_avg;
    assign o_out.long_average  = r_long_avg;
    assign o_out.short_char0   = r_short_txt.c0;
    assign o_out.short_char1   = r_short_txt.c1;
    assign o_out.short_char2   = r_short_txt.c2;
    assign o_out.long_char0    = r_long_txt.c0;
    assign o_out.long_char1    = r_long_txt.c1;
    assign o_out.long_char2    = r_long_txt.c2;

endmodule

@@ rtl/core/dwma_checker.sv @@
// ----------------------------------------------------------------------------
// dwma_checker
// port level checks of the dual window moving average
// ----------------------------------------------------------------------------
module dwma_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [dwma_pkg::AVG_W-1:0]  i_short_average,
    input logic [dwma_pkg::AVG_W-1:0]  i_long_average,
    input logic [dwma_pkg::CHAR_W-1:0] i_short_char0,
    input logic [dwma_pkg::CHAR_W-1:0] i_short_char1,
    input logic [dwma_pkg::CHAR_W-1:0] i_short_char2,
    input logic [dwma_pkg::CHAR_W-1:0] i_long_char0,
    input logic [dwma_pkg::CHAR_W-1:0] i_long_char1,
    input logic [dwma_pkg::CHAR_W-1:0] i_long_char2
);

    // nothing comes out the cycle after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    // stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_short_average) && $stable(i_long_average))
        else $error("stalled result changed");

    // leading character is always a digit
    a_lead_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_short_char0 != dwma_pkg::ASCII_SPACE
                     && i_long_char0 != dwma_pkg::ASCII_SPACE)
        else $error("leading character is a space");

    // single digit short means pad two spaces
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_short_average < 8'd10 |->
            i_short_char1 == dwma_pkg::ASCII_SPACE && i_short_char2 == dwma_pkg::ASCII_SPACE)
        else $error("short text padding wrong");

    // three digit long means carry no padding
    a_full_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_long_average >= 8'd100 |->
            i_long_char1 != dwma_pkg::ASCII_SPACE && i_long_char2 != dwma_pkg::ASCII_SPACE)
        else $error("long text has padding");

endmodule

bind dual_window_moving_average_top dwma_checker u_dwma_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_short_average (o_out.short_average),
    .i_long_average  (o_out.long_average),
    .i_short_char0   (o_out.short_char0),
    .i_short_char1   (o_out.short_char1),
    .i_short_char2   (o_out.short_char2),
    .i_long_char0    (o_out.long_char0),
    .i_long_char1    (o_out.long_char1),
    .i_long_char2    (o_out.long_char2)
);

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the dual window moving average
// ----------------------------------------------------------------------------
// Drives sample triples over the input channel and checks every output
// transfer against a local model of the two running-sum windows and their
// decimal text. A short table of directed rows comes first, then bursts of
// constant levels that fill one or both windows, amid fully random samples.
// Both channel sides idle at random; the receiver also holds off once for a
// long stretch, and the sender once waits for the pipeline to drain.
// ----------------------------------------------------------------------------
module testbench;

    localparam int SHORT_DEPTH  = 8;
    localparam int LONG_DEPTH   = 50;
    localparam int RANDOM_ITEMS = 1600;
    localparam int IDLE_PCT     = 12;
    localparam int CALM_FROM    = 600;
    localparam int CALM_TO      = 900;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 150;
    localparam int PAUSE_AT     = 1100;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int NUM_ROWS     = 20;

    localparam logic [dwma_pkg::CHAR_W-1:0] TXT_SPACE = dwma_pkg::ASCII_SPACE;
    localparam logic [dwma_pkg::CHAR_W-1:0] TXT_ZERO  = dwma_pkg::ASCII_ZERO;

    typedef logic [dwma_pkg::SAMPLE_W-1:0] t_sample;

    typedef struct packed {
        logic [dwma_pkg::AVG_W-1:0]  short_avg;
        logic [dwma_pkg::AVG_W-1:0]  long_avg;
        logic [dwma_pkg::CHAR_W-1:0] short_c0;
        logic [dwma_pkg::CHAR_W-1:0] short_c1;
        logic [dwma_pkg::CHAR_W-1:0] short_c2;
        logic [dwma_pkg::CHAR_W-1:0] long_c0;
        logic [dwma_pkg::CHAR_W-1:0] long_c1;
        logic [dwma_pkg::CHAR_W-1:0] long_c2;
    } t_means;

    typedef struct packed {
        t_sample a;
        t_sample b;
        t_sample c;
        logic    typed;
        t_means  want;
    } t_vector;

    // directed rows; a want is typed in only where it is plain from the math
    localparam t_vector DIRECTED [NUM_ROWS] = '{
        // all zero right after reset
        '{8'd0, 8'd0, 8'd0, 1'b1, '{8'd0, 8'd0, TXT_ZERO, TXT_SPACE, TXT_SPACE,
                                    TXT_ZERO, TXT_SPACE, TXT_SPACE}},
        // full scale into nearly empty windows: 255/8 and 255/50
        '{8'd255, 8'd255, 8'd255, 1'b1, '{8'd31, 8'd5, TXT_ZERO + 6'd3, TXT_ZERO + 6'd1,
                                          TXT_SPACE, TXT_ZERO + 6'd5, TXT_SPACE,
                                          TXT_SPACE}},
        '{8'd255, 8'd255, 8'd254, 1'b0, '0},
        '{8'd255, 8'd254, 8'd254, 1'b0, '0},
        '{8'd1,   8'd0,   8'd0,   1'b0, '0},
        '{8'd1,   8'd1,   8'd0,   1'b0, '0},
        '{8'd2,   8'd2,   8'd1,   1'b0, '0},
        '{8'hAA,  8'h55,  8'hFF,  1'b0, '0},
        '{8'h55,  8'hAA,  8'h00,  1'b0, '0},
        // seven full scale rows; with the next one they fill the short window
        '{8'd255, 8'd255, 8'd255, 1'b0, '0},
        '{8'd255, 8'd255, 8'd255, 1'b0, '0},
        '{8'd255, 8'd255, 8'd255, 1'b0, '0},
        '{8'd255, 8'd255, 8'd255, 1'b0, '0},
        '{8'd255, 8'd255, 8'd255, 1'b0, '0},
        '{8'd255, 8'd255, 8'd255, 1'b0, '0},
        '{8'd255, 8'd255, 8'd255, 1'b0, '0},
        // short window all 255, long window sum 3059 -> 61
        '{8'd255, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd61, TXT_ZERO + 6'd2,
                                          TXT_ZERO + 6'd5, TXT_ZERO + 6'd5,
                                          TXT_ZERO + 6'd6, TXT_ZERO + 6'd1,
                                          TXT_SPACE}},
        '{8'd254, 8'd0,   8'd0,   1'b0, '0},
        '{8'd0,   8'd0,   8'd255, 1'b0, '0},
        '{8'd128, 8'd64,  8'd32,  1'b0, '0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    dwma_in_if  in_ch ();
    dwma_out_if out_ch ();

    dual_window_moving_average_top #(
        .SHORT_WINDOW (SHORT_DEPTH),
        .LONG_WINDOW  (LONG_DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // local copy of both windows
    t_sample     short_hist [SHORT_DEPTH];
    t_sample     long_hist  [LONG_DEPTH];
    int unsigned short_pos;
    int unsigned long_pos;
    int unsigned short_sum;
    int unsigned long_sum;

    t_means expected_means [$];
    int     accepted = 0;
    int     failures = 0;
    int     cycles   = 0;
    bit     drained_once = 1'b0;

    // no idling on either side while this is high
    wire calm = (accepted >= CALM_FROM) && (accepted < CALM_TO);

    // left-justified decimal, space padded
    function automatic logic [3*dwma_pkg::CHAR_W-1:0] decimal_text(
        input logic [dwma_pkg::AVG_W-1:0] v);
        int unsigned                 n;
        logic [dwma_pkg::CHAR_W-1:0] h;
        logic [dwma_pkg::CHAR_W-1:0] t;
        logic [dwma_pkg::CHAR_W-1:0] u;
        n = v;
        h = TXT_ZERO + dwma_pkg::CHAR_W'(n / 100);
        t = TXT_ZERO + dwma_pkg::CHAR_W'((n / 10) % 10);
        u = TXT_ZERO + dwma_pkg::CHAR_W'(n % 10);
        if (n >= 100)
            return {h, t, u};
        else if (n >= 10)
            return {t, u, TXT_SPACE};
        return {u, TXT_SPACE, TXT_SPACE};
    endfunction

    // push one combined sample into both windows and return both means
    function automatic t_means advance_windows(input t_sample a, input t_sample b,
                                               input t_sample c);
        int unsigned level;
        t_means      m;
        level = (int'(a) + int'(b) + int'(c)) / 3;
        short_sum = short_sum - short_hist[short_pos] + level;
        short_hist[short_pos] = t_sample'(level);
        short_pos = (short_pos + 1 == SHORT_DEPTH) ? 0 : short_pos + 1;
        long_sum = long_sum - long_hist[long_pos] + level;
        long_hist[long_pos] = t_sample'(level);
        long_pos = (long_pos + 1 == LONG_DEPTH) ? 0 : long_pos + 1;
        m.short_avg = dwma_pkg::AVG_W'(short_sum / SHORT_DEPTH);
        m.long_avg  = dwma_pkg::AVG_W'(long_sum / LONG_DEPTH);
        {m.short_c0, m.short_c1, m.short_c2} = decimal_text(m.short_avg);
        {m.long_c0, m.long_c1, m.long_c2}    = decimal_text(m.long_avg);
        return m;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    // one input transfer, starting and ending at a falling edge
    task automatic offer(input t_sample a, input t_sample b, input t_sample c,
                         input logic typed, input t_means want);
        t_means predicted;
        // sender pause: once, let every pending result come out first
        if (!drained_once && accepted >= PAUSE_AT) begin
            drained_once = 1'b1;
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
            while (expected_means.size() != 0)
                @(negedge i_clk);
        end
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.sample_a <= a;
        in_ch.sample_b <= b;
        in_ch.sample_c <= c;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        predicted = advance_windows(a, b, c);
        expected_means.push_back(typed ? want : predicted);
        accepted++;
        @(negedge i_clk);
    endtask

    // stimulus
    initial begin
        int unsigned mode;
        int unsigned level;
        int unsigned spread;
        int unsigned run;
        int unsigned d;
        i_rst_n        <= 1'b0;
        in_ch.valid    <= 1'b0;
        in_ch.sample_a <= '0;
        in_ch.sample_b <= '0;
        in_ch.sample_c <= '0;
        foreach (short_hist[k]) short_hist[k] = '0;
        foreach (long_hist[k]) long_hist[k] = '0;
        short_pos = 0;
        long_pos  = 0;
        short_sum = 0;
        long_sum  = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[r])
            offer(DIRECTED[r].a, DIRECTED[r].b, DIRECTED[r].c, DIRECTED[r].typed,
                  DIRECTED[r].want);

        // constant-level bursts long enough to fill one or both windows,
        // mixed with runs of fully random samples
        while (accepted < NUM_ROWS + RANDOM_ITEMS) begin
            mode = $urandom_range(99);
            if (mode < 60) begin
                case ($urandom_range(7))
                    0: level = 0;
                    1: level = 9;
                    2: level = 10;
                    3: level = 99;
                    4: level = 100;
                    5: level = 254;
                    6: level = 255;
                    default: level = $urandom_range(255);
                endcase
                spread = (level < 255 - level) ? level : 255 - level;
                run = $urandom_range(60, 8);
                repeat (run) begin
                    // same combined value, different raw samples
                    d = $urandom_range(spread);
                    if ($urandom_range(3) == 0)
                        offer(t_sample'(level), t_sample'(level + d), t_sample'(level - d),
                              1'b0, '0);
                    else
                        offer(t_sample'(level), t_sample'(level), t_sample'(level),
                              1'b0, '0);
                end
            end else begin
                run = $urandom_range(20, 1);
                repeat (run)
                    offer(t_sample'($urandom_range(255)), t_sample'($urandom_range(255)),
                          t_sample'($urandom_range(255)), 1'b0, '0);
            end
        end

        in_ch.valid <= 1'b0;
        while (expected_means.size() != 0)
            @(negedge i_clk);
        // wait a further DRAIN_CYCLES so a stray extra transfer would still show up
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (failures == 0)
            $display("dual_window_moving_average_top test passed");
        else
            $display("dual_window_moving_average_top test failed");
        $finish;
    end

    // receiver side: random ready, one long hold-off to back up the pipeline
    initial begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && accepted >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // output checker
    always @(posedge i_clk) begin
        t_means got;
        t_means want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = '{out_ch.short_average, out_ch.long_average,
                    out_ch.short_char0, out_ch.short_char1, out_ch.short_char2,
                    out_ch.long_char0, out_ch.long_char1, out_ch.long_char2};
            if (expected_means.size() == 0) begin
                $error("output transfer with no result pending");
                failures++;
            end else begin
                want = expected_means.pop_front();
                check_field("short_average", 32'(want.short_avg), 32'(got.short_avg));
                check_field("long_average", 32'(want.long_avg), 32'(got.long_avg));
                check_field("short_char0", 32'(want.short_c0), 32'(got.short_c0));
                check_field("short_char1", 32'(want.short_c1), 32'(got.short_c1));
                check_field("short_char2", 32'(want.short_c2), 32'(got.short_c2));
                check_field("long_char0", 32'(want.long_c0), 32'(got.long_c0));
                check_field("long_char1", 32'(want.long_c1), 32'(got.long_c1));
                check_field("long_char2", 32'(want.long_c2), 32'(got.long_c2));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("dual_window_moving_average_top test failed");
            $finish;
        end
    end

endmodule
